### hw/rtl/phfl_pkg.sv
// Package for the four-lane Pearson hash: lane count, permutation table,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package phfl_pkg;

	localparam int LANES = 4;
	localparam int BYTE_W = 8;
	localparam int HASH_W = LANES * BYTE_W;
	localparam int COUNT_W = 3;
	localparam int IDX_W = $clog2(LANES);

	// Fixed 256-entry permutation of the byte values
	localparam logic [BYTE_W-1:0] PERM_TABLE [0:255] = '{
		8'd251, 8'd175, 8'd119, 8'd215, 8'd81,  8'd14,  8'd79,  8'd191,
		8'd103, 8'd49,  8'd181, 8'd143, 8'd186, 8'd157, 8'd0,   8'd232,
		8'd31,  8'd32,  8'd55,  8'd60,  8'd152, 8'd58,  8'd17,  8'd237,
		8'd174, 8'd70,  8'd160, 8'd144, 8'd220, 8'd90,  8'd57,  8'd223,
		8'd59,  8'd3,   8'd18,  8'd140, 8'd111, 8'd166, 8'd203, 8'd196,
		8'd134, 8'd243, 8'd124, 8'd95,  8'd222, 8'd179, 8'd197, 8'd65,
		8'd180, 8'd48,  8'd36,  8'd15,  8'd107, 8'd46,  8'd233, 8'd130,
		8'd165, 8'd30,  8'd123, 8'd161, 8'd209, 8'd23,  8'd97,  8'd16,
		8'd40,  8'd91,  8'd219, 8'd61,  8'd100, 8'd10,  8'd210, 8'd109,
		8'd250, 8'd127, 8'd22,  8'd138, 8'd29,  8'd108, 8'd244, 8'd67,
		8'd207, 8'd9,   8'd178, 8'd204, 8'd74,  8'd98,  8'd126, 8'd249,
		8'd167, 8'd116, 8'd34,  8'd77,  8'd193, 8'd200, 8'd121, 8'd5,
		8'd20,  8'd113, 8'd71,  8'd35,  8'd128, 8'd13,  8'd182, 8'd94,
		8'd25,  8'd226, 8'd227, 8'd199, 8'd75,  8'd27,  8'd41,  8'd245,
		8'd230, 8'd224, 8'd43,  8'd225, 8'd177, 8'd26,  8'd155, 8'd150,
		8'd212, 8'd142, 8'd218, 8'd115, 8'd241, 8'd73,  8'd88,  8'd105,
		8'd39,  8'd114, 8'd62,  8'd255, 8'd192, 8'd201, 8'd145, 8'd214,
		8'd168, 8'd158, 8'd221, 8'd148, 8'd154, 8'd122, 8'd12,  8'd84,
		8'd82,  8'd163, 8'd44,  8'd139, 8'd228, 8'd236, 8'd205, 8'd242,
		8'd217, 8'd11,  8'd187, 8'd146, 8'd159, 8'd64,  8'd86,  8'd239,
		8'd195, 8'd42,  8'd106, 8'd198, 8'd118, 8'd112, 8'd184, 8'd172,
		8'd87,  8'd2,   8'd173, 8'd117, 8'd176, 8'd229, 8'd247, 8'd253,
		8'd137, 8'd185, 8'd99,  8'd164, 8'd102, 8'd147, 8'd45,  8'd66,
		8'd231, 8'd52,  8'd141, 8'd211, 8'd194, 8'd206, 8'd246, 8'd238,
		8'd56,  8'd110, 8'd78,  8'd248, 8'd63,  8'd240, 8'd189, 8'd93,
		8'd92,  8'd51,  8'd53,  8'd183, 8'd19,  8'd171, 8'd72,  8'd50,
		8'd33,  8'd104, 8'd101, 8'd69,  8'd8,   8'd252, 8'd83,  8'd120,
		8'd76,  8'd135, 8'd85,  8'd54,  8'd202, 8'd125, 8'd188, 8'd213,
		8'd96,  8'd235, 8'd136, 8'd208, 8'd162, 8'd129, 8'd190, 8'd132,
		8'd156, 8'd38,  8'd47,  8'd1,   8'd7,   8'd254, 8'd24,  8'd4,
		8'd216, 8'd131, 8'd89,  8'd21,  8'd28,  8'd133, 8'd37,  8'd153,
		8'd149, 8'd80,  8'd170, 8'd68,  8'd6,   8'd169, 8'd234, 8'd151
	};

	typedef enum logic {
		ST_IDLE,
		ST_MIX
	} phfl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;   // input transaction this cycle
		logic step;   // one catch-up mix over a buffered head byte
	} phfl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;  // output register empty or draining this cycle
		logic catchup;   // the offered byte completes the head
		logic mix_last;  // current catch-up step is the final one
	} phfl_status_t;

endpackage

`default_nettype wire

### hw/rtl/phfl_byte_if.sv
// Byte stream channel: valid/ready handshake carrying one string byte and its end flag.
// Depends on phfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface phfl_byte_if;
	logic                      valid;
	logic                      ready;
	logic [phfl_pkg::BYTE_W-1:0] text_byte;
	logic                      end_of_string;

	modport source (output valid, output text_byte, output end_of_string, input ready);
	modport sink (input valid, input text_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### hw/rtl/phfl_hash_if.sv
// Hash result channel: valid/ready handshake carrying one 32-bit hash.
// Depends on phfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface phfl_hash_if;
	logic                      valid;
	logic                      ready;
	logic [phfl_pkg::HASH_W-1:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/phfl_ctrl.sv
// Controller for the four-lane Pearson hash: idle/catch-up state machine,
// input ready and datapath commands. Depends on phfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phfl_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  phfl_pkg::phfl_status_t  status,
	output phfl_pkg::phfl_cmd_t     cmd
);
	import phfl_pkg::*;

	phfl_state_t state_q;
	phfl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = status.out_free;
				cmd.take = in_valid && status.out_free;
				if (cmd.take && status.catchup) begin
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				cmd.step = 1'b1;
				if (status.mix_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/phfl_datapath.sv
// Datapath for the four-lane Pearson hash: head buffer, lane registers,
// table lookups and the output register. Depends on phfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module phfl_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  phfl_pkg::phfl_cmd_t          cmd,
	output phfl_pkg::phfl_status_t       status,
	input  wire [phfl_pkg::BYTE_W-1:0]   text_byte,
	input  wire                          end_of_string,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [phfl_pkg::HASH_W-1:0]  hash_value
);
	import phfl_pkg::*;

	logic [COUNT_W-1:0] head_count_q;
	logic [BYTE_W-1:0]  head_q [LANES];
	logic [BYTE_W-1:0]  head_new [LANES];
	logic [BYTE_W-1:0]  lane_q [LANES];
	logic [BYTE_W-1:0]  lane_mixed [LANES];
	logic [BYTE_W-1:0]  lane_seed [LANES];
	logic [IDX_W-1:0]   mix_idx_q;
	logic [IDX_W-1:0]   last_idx_q;
	logic               last_q;
	logic               out_valid_q;
	logic [HASH_W-1:0]  hash_q;

	logic               streaming;
	logic [IDX_W-1:0]   head_idx;
	logic [BYTE_W-1:0]  mix_byte;
	logic [HASH_W-1:0]  mixed_packed;
	logic               load_out;

	// Counts of four and above behave as streaming
	assign streaming = head_count_q[COUNT_W-1];
	assign head_idx  = head_count_q[IDX_W-1:0];

	assign status.out_free = !out_valid_q || out_ready;
	assign status.catchup  = !streaming &&
		(head_idx == IDX_W'(LANES - 1) || end_of_string);
	assign status.mix_last = (mix_idx_q == last_idx_q);

	// Head as it stands with the offered byte written in
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			head_new[i] = (!streaming && head_idx == IDX_W'(i)) ? text_byte : head_q[i];
		end
	end

	// Seed lane u with head byte (u mod n); n - 1 equals head_idx here
	always_comb begin
		lane_seed[0] = head_new[0];
		lane_seed[1] = (head_idx >= IDX_W'(1)) ? head_new[1] : head_new[0];
		lane_seed[2] = (head_idx >= IDX_W'(2)) ? head_new[2] : head_new[0];
		priority if (head_idx == IDX_W'(3)) begin
			lane_seed[3] = head_new[3];
		end else if (head_idx == IDX_W'(1)) begin
			lane_seed[3] = head_new[1];
		end else begin
			lane_seed[3] = head_new[0];
		end
	end

	assign mix_byte = cmd.step ? head_q[mix_idx_q] : text_byte;

	always_comb begin
		for (int u = 0; u < LANES; u++) begin
			lane_mixed[u] = PERM_TABLE[lane_q[u] ^ mix_byte];
			mixed_packed[u*BYTE_W +: BYTE_W] = lane_mixed[u];
		end
	end

	assign load_out = (cmd.take && streaming && end_of_string) ||
		(cmd.step && status.mix_last && last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_count_q <= '0;
			out_valid_q  <= 1'b0;
			mix_idx_q    <= '0;
		end else begin
			if (cmd.take) begin
				if (streaming) begin
					if (end_of_string) begin
						head_count_q <= '0;
					end
				end else begin
					head_count_q <= head_count_q + COUNT_W'(1);
					mix_idx_q    <= '0;
				end
			end else if (cmd.step) begin
				mix_idx_q <= mix_idx_q + IDX_W'(1);
				if (status.mix_last) begin
					head_count_q <= last_q ? '0 : COUNT_W'(LANES);
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !streaming) begin
			for (int i = 0; i < LANES; i++) begin
				head_q[i] <= head_new[i];
			end
			if (status.catchup) begin
				for (int u = 0; u < LANES; u++) begin
					lane_q[u] <= lane_seed[u];
				end
				last_idx_q <= head_idx;
				last_q     <= end_of_string;
			end
		end else if ((cmd.take && streaming) || cmd.step) begin
			for (int u = 0; u < LANES; u++) begin
				lane_q[u] <= lane_mixed[u];
			end
		end

		if (load_out) begin
			hash_q <= mixed_packed;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

`default_nettype wire

### hw/rtl/pearson_hash_four_lane.sv
// Four-lane Pearson string hash, top level: joins the controller and the datapath
// to the byte and hash channels. Depends on phfl_pkg, phfl_byte_if, phfl_hash_if,
// phfl_ctrl and phfl_datapath.
//
// Usage:
//   text_chan carries a string one byte per transaction, end_of_string set on its
//   final byte. hash_chan carries one 32-bit hash per string, lane 0 in bits 7:0.
//   Bytes after the fourth stream into the lanes at one byte per cycle unless the
//   output register is stalled; the hash of a string that ends in this streaming
//   phase is valid the cycle after its final byte is taken.
//   The first four bytes are held in a head buffer because they also seed the
//   lanes. The transaction that completes the head (the fourth byte, or the final
//   byte of a shorter string of n bytes) seeds the lanes and is followed by a
//   catch-up (n = 4, or the string length if shorter) during which the n buffered
//   bytes are mixed one per cycle and ready is low. A short string's hash is loaded
//   into the output register on the final catch-up step.
//   The result sits in an output register. While it waits, ready stays high only
//   if the receiver takes it in the same cycle; a stalled receiver holds off new
//   bytes and the hash stays stable until taken.
//   Reset (arst_n low) empties the head buffer and drops any pending result; the
//   next byte starts a new string.
`timescale 1ns / 1ps
`default_nettype none

module pearson_hash_four_lane (
	input wire          clk,
	input wire          arst_n,
	phfl_byte_if.sink   text_chan,
	phfl_hash_if.source hash_chan
);
	import phfl_pkg::*;

	phfl_cmd_t    cmd;
	phfl_status_t status;

	// Sequencing: idle versus catch-up over the buffered head
	phfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_chan.valid),
		.in_ready (text_chan.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Lanes, head buffer, table lookups and result register
	phfl_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.text_byte     (text_chan.text_byte),
		.end_of_string (text_chan.end_of_string),
		.out_valid     (hash_chan.valid),
		.out_ready     (hash_chan.ready),
		.hash_value    (hash_chan.hash_value)
	);

endmodule

`default_nettype wire

### tb/pearson_hash_four_lane_tb.sv
// Self-checking testbench for the four-lane Pearson string hash: directed and random
// strings, random idling on both channels, hashes checked against an in-bench predictor.
// Depends on phfl_pkg, phfl_byte_if, phfl_hash_if and pearson_hash_four_lane.
`timescale 1ns / 1ps

module pearson_hash_four_lane_tb;

	import phfl_pkg::*;

	// Pacing of the two channels; each queued byte carries the pacing it is sent under
	typedef enum logic [1:0] {
		PACE_STEADY,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH_IDLE
	} pace_t;

	typedef struct {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_string;
		pace_t             pace;
	} text_txn_t;

	localparam int RANDOM_BYTES = 450;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int REPORT_MAX   = 10;

	logic clk = 1'b0;
	logic arst_n;

	phfl_byte_if text_if ();
	phfl_hash_if hash_if ();

	pearson_hash_four_lane DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_chan(text_if),
		.hash_chan(hash_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_txn_t         pending_bytes [$];
	logic [HASH_W-1:0] expected_hashes [$];
	pace_t             cur_pace;
	int                mismatches;
	int                cycle_count;

	// Predictor state: the head buffer, its fill level and the four lanes
	logic [BYTE_W-1:0]  head_buf [LANES];
	logic [COUNT_W-1:0] head_fill;
	logic [BYTE_W-1:0]  lane_acc [LANES];

	function automatic int send_idle_pct(pace_t p);
		case (p)
			PACE_SEND_IDLE: return 53;
			PACE_BOTH_IDLE: return 30;
			default:        return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(pace_t p);
		case (p)
			PACE_RECV_STALL: return 53;
			PACE_BOTH_IDLE:  return 30;
			default:         return 0;
		endcase
	endfunction

	// Pass one byte through every lane
	task automatic mix_lanes(input logic [BYTE_W-1:0] b);
		for (int u = 0; u < LANES; u++)
			lane_acc[u] = PERM_TABLE[lane_acc[u] ^ b];
	endtask

	// Advance the predicted hash state by one accepted byte; queue a hash on the last one
	task automatic hash_absorb(input logic [BYTE_W-1:0] b, input logic last);
		int n;
		if (head_fill < LANES) begin
			head_buf[head_fill[IDX_W-1:0]] = b;
			head_fill = head_fill + 1'b1;
			n = head_fill;
			// A full head, or a short string ending early: seed by cycling the head
			if (n == LANES || last) begin
				for (int u = 0; u < LANES; u++)
					lane_acc[u] = head_buf[u % n];
				for (int u = 0; u < n; u++)
					mix_lanes(head_buf[u]);
				head_fill = COUNT_W'(LANES);
			end
		end else begin
			mix_lanes(b);
		end
		if (last) begin
			expected_hashes.push_back({lane_acc[3], lane_acc[2], lane_acc[1], lane_acc[0]});
			head_fill = '0;
		end
	endtask

	task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last, input pace_t p);
		text_txn_t t;
		t.text_byte     = b;
		t.end_of_string = last;
		t.pace          = p;
		pending_bytes.push_back(t);
	endtask

	// Driver: offer the next pending byte unless the sender idles this cycle; hold an
	// offered byte until the block takes it, and predict on every accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			head_fill     <= '0;
		end else begin
			if (text_if.valid && text_if.ready)
				hash_absorb(text_if.text_byte, text_if.end_of_string);
			if (!text_if.valid || text_if.ready) begin
				if (pending_bytes.size() != 0 &&
				    $urandom_range(99) >= send_idle_pct(pending_bytes[0].pace)) begin
					text_if.valid         <= 1'b1;
					text_if.text_byte     <= pending_bytes[0].text_byte;
					text_if.end_of_string <= pending_bytes[0].end_of_string;
					cur_pace              <= pending_bytes[0].pace;
					void'(pending_bytes.pop_front());
				end else begin
					text_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each hash transaction with the oldest prediction, then decide
	// whether the receiver stalls in the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_if.ready <= 1'b0;
		end else begin
			if (hash_if.valid && hash_if.ready) begin
				if (expected_hashes.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("[%0t] unexpected hash 0x%08h, none predicted",
						         $realtime, hash_if.hash_value);
				end else begin
					if (hash_if.hash_value !== expected_hashes[0]) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("[%0t] hash_value mismatch: expected 0x%08h, got 0x%08h",
							         $realtime, expected_hashes[0], hash_if.hash_value);
					end
					void'(expected_hashes.pop_front());
				end
			end
			hash_if.ready <= ($urandom_range(99) >= recv_stall_pct(cur_pace));
		end
	end

	// Watchdog: end a run that hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		// Directed strings: single bytes at both extremes, each short length, the exact
		// head length and a string one past it, then a longer streaming one
		logic [BYTE_W-1:0] directed_bytes [$];
		int                directed_lens [$];
		int                pos;
		int                sent;
		int                len;
		int                r;
		pace_t             p;

		directed_bytes = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80,
		                   8'h01, 8'h02, 8'h04, 8'h08,
		                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		                   8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h7E, 8'h81};
		directed_lens  = '{1, 1, 2, 3, 4, 5, 6};

		arst_n          = 1'b0;
		cur_pace        = PACE_STEADY;
		mismatches      = 0;
		text_if.valid   = 1'b0;
		text_if.text_byte     = '0;
		text_if.end_of_string = 1'b0;
		hash_if.ready   = 1'b0;

		pos = 0;
		foreach (directed_lens[i]) begin
			for (int k = 0; k < directed_lens[i]; k++)
				queue_byte(directed_bytes[pos + k], k == directed_lens[i] - 1, PACE_STEADY);
			pos += directed_lens[i];
		end

		// Random strings, mostly short, some long; step through each pacing in turn
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			r = $urandom_range(99);
			if (r < 40)
				len = $urandom_range(1, 4);
			else if (r < 90)
				len = $urandom_range(5, 12);
			else
				len = $urandom_range(13, 40);
			p = pace_t'((sent * 4) / RANDOM_BYTES);
			for (int k = 0; k < len; k++)
				queue_byte(8'($urandom), k == len - 1, p);
			sent += len;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every byte taken and every predicted hash seen
		while (pending_bytes.size() != 0 || text_if.valid || expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_hashes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
